// File: design/advdp_pkg.sv
// Package with types and constants shared by the advertising data structure parser.
`default_nettype none

package advdp_pkg;

  localparam logic [15:0] CID_RESET = 16'h004C;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] TYPE_FLAGS      = 8'h01;
  localparam logic [7:0] TYPE_SVC_FIRST  = 8'h02;
  localparam logic [7:0] TYPE_SVC_LAST   = 8'h07;
  localparam logic [7:0] TYPE_NAME_SHORT = 8'h08;
  localparam logic [7:0] TYPE_NAME_FULL  = 8'h09;
  localparam logic [7:0] TYPE_TX_POWER   = 8'h0A;
  localparam logic [7:0] TYPE_MANUF      = 8'hFF;

  localparam logic [7:0] BEACON_SUBTYPE  = 8'h02;
  localparam logic [7:0] BEACON_MIN_LEN  = 8'h15;

  typedef enum logic [1:0] {
    KIND_SERVICE,
    KIND_NAME,
    KIND_UUID,
    KIND_SUMMARY
  } kind_t;

  typedef enum logic [1:0] {
    PH_LENGTH,
    PH_TYPE,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  index;
    logic [7:0]  value;
    logic [7:0]  flags_value;
    logic [7:0]  tx_power;
    logic        is_beacon;
    logic [15:0] beacon_major;
    logic [15:0] beacon_minor;
    logic [2:0]  service_type;
    logic [7:0]  service_length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic byte_vld;
    logic sum_vld;
    res_t byte_res;
    res_t sum_res;
  } push_t;

endpackage

`default_nettype wire

// File: design/advdp_if.sv
// Interfaces for the byte input channel and the result output channel.
`default_nettype none

interface advdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] packet_length;

  modport source (output valid, output data_byte, output packet_length, input ready);
  modport sink (input valid, input data_byte, input packet_length, output ready);
endinterface

interface advdp_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        index;
  logic [7:0]        value;
  logic [7:0]        flags_value;
  logic signed [7:0] tx_power;
  logic              is_beacon;
  logic [15:0]       beacon_major;
  logic [15:0]       beacon_minor;
  logic [2:0]        service_type;
  logic [7:0]        service_length;
  logic              last;

  modport source (output valid, output kind, output index, output value,
                  output flags_value, output tx_power, output is_beacon,
                  output beacon_major, output beacon_minor, output service_type,
                  output service_length, output last, input ready);
  modport sink (input valid, input kind, input index, input value,
                input flags_value, input tx_power, input is_beacon,
                input beacon_major, input beacon_minor, input service_type,
                input service_length, input last, output ready);
endinterface

`default_nettype wire

// File: design/advdp_parse.sv
// Input register and structure walker that turns bytes into result words.
`default_nettype none

module advdp_parse
  import advdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] cid,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [7:0]  in_packet_length,
  input  wire logic        room,
  output push_t            push
);

  localparam logic [7:0] MP_CID_LO   = 8'd0;
  localparam logic [7:0] MP_CID_HI   = 8'd1;
  localparam logic [7:0] MP_SUBTYPE  = 8'd2;
  localparam logic [7:0] MP_LEN      = 8'd3;
  localparam logic [7:0] MP_UUID_LO  = 8'd4;
  localparam logic [7:0] MP_UUID_HI  = 8'd19;
  localparam logic [7:0] MP_MAJOR_HI = 8'd20;
  localparam logic [7:0] MP_MAJOR_LO = 8'd21;
  localparam logic [7:0] MP_MINOR_HI = 8'd22;
  localparam logic [7:0] MP_MINOR_LO = 8'd23;
  localparam logic [7:0] MP_POWER    = 8'd24;

  logic       iv_r;
  logic [7:0] ib_r;
  logic [7:0] il_r;
  logic       adv;
  logic       last;
  logic [8:0] off_inc;
  logic [9:0] need;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  off_r;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  stype_r, stype_nxt;
  logic [7:0]  ppos_r, ppos_nxt;
  logic        hdr_r, hdr_nxt;
  logic [7:0]  colow_r, colow_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  txp_r, txp_nxt;
  logic        beacon_r, beacon_nxt;
  logic [15:0] major_r, major_nxt;
  logic [15:0] minor_r, minor_nxt;
  logic [2:0]  sstype_r, sstype_nxt;
  logic [7:0]  sslen_r, sslen_nxt;

  logic is_svc;
  logic is_name;
  logic is_uuid;

  assign adv      = iv_r && room;
  assign in_ready = !iv_r || room;
  assign off_inc  = {1'b0, off_r} + 9'd1;
  assign last     = off_inc >= {1'b0, il_r};
  assign need     = {2'b00, off_r} + 10'd1 + {2'b00, ib_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_ready) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ib_r <= in_data_byte;
      il_r <= in_packet_length;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    rem_nxt    = rem_r;
    stype_nxt  = stype_r;
    ppos_nxt   = ppos_r;
    hdr_nxt    = hdr_r;
    colow_nxt  = colow_r;
    flags_nxt  = flags_r;
    txp_nxt    = txp_r;
    beacon_nxt = beacon_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    sstype_nxt = sstype_r;
    sslen_nxt  = sslen_r;
    unique case (phase_r)
      PH_LENGTH: begin
        if (ib_r != 8'd0) begin
          if (need > {2'b00, il_r}) begin
            phase_nxt = PH_STOPPED;
          end else begin
            rem_nxt   = ib_r - 8'd1;
            phase_nxt = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        stype_nxt = ib_r;
        ppos_nxt  = 8'd0;
        hdr_nxt   = 1'b0;
        if (ib_r >= TYPE_SVC_FIRST && ib_r <= TYPE_SVC_LAST) begin
          sstype_nxt = ib_r[2:0];
          sslen_nxt  = rem_r;
        end
        phase_nxt = (rem_r == 8'd0) ? PH_LENGTH : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (stype_r == TYPE_FLAGS) begin
          if (ppos_r == 8'd0) flags_nxt = ib_r;
        end else if (stype_r == TYPE_TX_POWER) begin
          if (ppos_r == 8'd0) txp_nxt = ib_r;
        end else if (stype_r == TYPE_MANUF) begin
          if (ppos_r == MP_CID_LO) begin
            colow_nxt = ib_r;
          end else if (ppos_r == MP_CID_HI) begin
            hdr_nxt = ({ib_r, colow_r} == cid);
          end else if (ppos_r == MP_SUBTYPE) begin
            if (ib_r != BEACON_SUBTYPE) hdr_nxt = 1'b0;
          end else if (ppos_r == MP_LEN) begin
            if (ib_r < BEACON_MIN_LEN) hdr_nxt = 1'b0;
            if (hdr_nxt) beacon_nxt = 1'b1;
          end else if (hdr_r) begin
            if (ppos_r == MP_MAJOR_HI || ppos_r == MP_MINOR_HI) begin
              colow_nxt = ib_r;
            end else if (ppos_r == MP_MAJOR_LO) begin
              major_nxt = {colow_r, ib_r};
            end else if (ppos_r == MP_MINOR_LO) begin
              minor_nxt = {colow_r, ib_r};
            end else if (ppos_r == MP_POWER) begin
              txp_nxt = ib_r;
            end
          end
        end
        ppos_nxt = ppos_r + 8'd1;
        rem_nxt  = rem_r - 8'd1;
        if (rem_nxt == 8'd0) phase_nxt = PH_LENGTH;
      end
      PH_STOPPED: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    is_svc  = stype_r >= TYPE_SVC_FIRST && stype_r <= TYPE_SVC_LAST;
    is_name = stype_r == TYPE_NAME_SHORT || stype_r == TYPE_NAME_FULL;
    is_uuid = stype_r == TYPE_MANUF && hdr_r && ppos_r >= MP_UUID_LO
              && ppos_r <= MP_UUID_HI;

    push.byte_vld = adv && phase_r == PH_PAYLOAD && (is_svc || is_name || is_uuid);
    push.byte_res = '0;
    push.byte_res.value = ib_r;
    if (is_svc) begin
      push.byte_res.kind  = KIND_SERVICE;
      push.byte_res.index = ppos_r;
    end else if (is_name) begin
      push.byte_res.kind  = KIND_NAME;
      push.byte_res.index = ppos_r;
    end else begin
      push.byte_res.kind  = KIND_UUID;
      push.byte_res.index = ppos_r - MP_UUID_LO;
    end

    push.sum_vld = adv && last;
    push.sum_res = '0;
    push.sum_res.kind           = KIND_SUMMARY;
    push.sum_res.flags_value    = flags_nxt;
    push.sum_res.tx_power       = txp_nxt;
    push.sum_res.is_beacon      = beacon_nxt;
    push.sum_res.beacon_major   = major_nxt;
    push.sum_res.beacon_minor   = minor_nxt;
    push.sum_res.service_type   = sstype_nxt;
    push.sum_res.service_length = sslen_nxt;
    push.sum_res.last           = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && last)) begin
      phase_r  <= PH_LENGTH;
      off_r    <= '0;
      rem_r    <= '0;
      stype_r  <= '0;
      ppos_r   <= '0;
      hdr_r    <= 1'b0;
      colow_r  <= '0;
      flags_r  <= '0;
      txp_r    <= '0;
      beacon_r <= 1'b0;
      major_r  <= '0;
      minor_r  <= '0;
      sstype_r <= '0;
      sslen_r  <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      off_r    <= off_inc[7:0];
      rem_r    <= rem_nxt;
      stype_r  <= stype_nxt;
      ppos_r   <= ppos_nxt;
      hdr_r    <= hdr_nxt;
      colow_r  <= colow_nxt;
      flags_r  <= flags_nxt;
      txp_r    <= txp_nxt;
      beacon_r <= beacon_nxt;
      major_r  <= major_nxt;
      minor_r  <= minor_nxt;
      sstype_r <= sstype_nxt;
      sslen_r  <= sslen_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last) |=> (off_r == 8'd0 && phase_r == PH_LENGTH))
    else $error("packet state not cleared after last word");

  a_payload_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (rem_r != 8'd0))
    else $error("payload phase with no bytes remaining");

  a_byte_phase: assert property (@(posedge clk) disable iff (!rst_n)
    push.byte_vld |-> (phase_r == PH_PAYLOAD && iv_r))
    else $error("field word emitted outside a structure payload");

endmodule

`default_nettype wire

// File: design/advdp_outq.sv
// Result queue that takes up to two words per cycle and hands out one.
`default_nettype none

module advdp_outq
  import advdp_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      head
);

  localparam int unsigned PW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  res_t          mem_r [Depth];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] wr1;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    push_n;
  logic          pop;
  res_t          w0;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_n    = {1'b0, push.byte_vld} + {1'b0, push.sum_vld};
  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign room      = cnt_r <= CW'(Depth - 2);
  assign w0        = push.byte_vld ? push.byte_res : push.sum_res;
  assign wr1       = wrap_inc(wr_ptr_r);

  always_comb begin
    cnt_nxt = cnt_r + CW'(push_n) - CW'(pop);
    unique case (push_n)
      2'd0:    wr_ptr_nxt = wr_ptr_r;
      2'd1:    wr_ptr_nxt = wr1;
      default: wr_ptr_nxt = wrap_inc(wr1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_ptr_r] <= w0;
    if (push_n == 2'd2) mem_r[wr1] <= push.sum_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
      if (pop) rd_ptr_r <= wrap_inc(rd_ptr_r);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(Depth))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room)
    else $error("word pushed without room in result queue");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd2) |-> (push.sum_res.last && push.byte_res.kind != KIND_SUMMARY))
    else $error("two words pushed without a summary behind a field word");

endmodule

`default_nettype wire

// File: design/adv_data_structure_parser.sv
// Top level of the advertising data structure parser.
// A byte is held in the input register, then parsed and its result words pushed into
// the result queue, from whose head they are offered.
// Throughput: one byte per cycle while the queue holds at most QueueDepth-2 words; the
// last byte of a packet may add two words, so a run of short packets stalls the input.
// Reset is synchronous and active low; it clears all parse state and the queue and
// sets the beacon company id to 0x004C.
`default_nettype none

module adv_data_structure_parser
  import advdp_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  advdp_in_if.sink         in_ch,
  advdp_out_if.source      out_ch
);

  logic [15:0] cid_r;
  logic        room;
  push_t       push;
  res_t        head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cid_r <= CID_RESET;
    end else if (cfg_we) begin
      cid_r <= cfg_wdata;
    end
  end

  advdp_parse u_parse (
    .clk              (clk),
    .rst_n            (rst_n),
    .cid              (cid_r),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_data_byte     (in_ch.data_byte),
    .in_packet_length (in_ch.packet_length),
    .room             (room),
    .push             (push)
  );

  advdp_outq #(
    .Depth (QueueDepth)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .head      (head)
  );

  assign out_ch.kind           = head.kind;
  assign out_ch.index          = head.index;
  assign out_ch.value          = head.value;
  assign out_ch.flags_value    = head.flags_value;
  assign out_ch.tx_power       = head.tx_power;
  assign out_ch.is_beacon      = head.is_beacon;
  assign out_ch.beacon_major   = head.beacon_major;
  assign out_ch.beacon_minor   = head.beacon_minor;
  assign out_ch.service_type   = head.service_type;
  assign out_ch.service_length = head.service_length;
  assign out_ch.last           = head.last;

endmodule

`default_nettype wire
